### rtl/u8u16_pkg.sv
// Package: shared constants and queue entry type for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps

package u8u16_pkg;

  localparam int UNIT_W      = 21;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [UNIT_W-1:0] REPL_CHAR    = 21'h00FFFD;
  localparam logic [UNIT_W-1:0] SUPP_BASE    = 21'h010000;
  localparam logic [UNIT_W-1:0] SURR_HI_BASE = 21'h00D800;
  localparam logic [UNIT_W-1:0] SURR_LO_BASE = 21'h00DC00;

  localparam logic [7:0] CONT_LO    = 8'h80;
  localparam logic [7:0] CONT_HI    = 8'hBF;
  localparam logic [7:0] CONT_MASK  = 8'h3F;
  localparam logic [7:0] E0_LO      = 8'hA0;
  localparam logic [7:0] ED_HI      = 8'h9F;
  localparam logic [7:0] F0_LO      = 8'h90;
  localparam logic [7:0] F4_HI      = 8'h8F;
  localparam logic [7:0] LEAD2_MIN  = 8'hC2;
  localparam logic [7:0] LEAD2_MAX  = 8'hDF;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD3_MAX  = 8'hEF;
  localparam logic [7:0] LEAD4_MIN  = 8'hF0;
  localparam logic [7:0] LEAD4_MAX  = 8'hF4;
  localparam logic [7:0] LEAD_E0    = 8'hE0;
  localparam logic [7:0] LEAD_ED    = 8'hED;
  localparam logic [7:0] LEAD_F0    = 8'hF0;
  localparam logic [7:0] LEAD_F4    = 8'hF4;

  localparam logic FMT_UTF32 = 1'b0;
  localparam logic FMT_UTF16 = 1'b1;

  // One queue entry: the one or two results of one input byte.
  typedef struct packed {
    logic [UNIT_W-1:0] unit0;
    logic              repl0;
    logic [UNIT_W-1:0] unit1;
    logic              repl1;
    logic              two;
    logic              eos;
  } q_entry_t;

endpackage

### rtl/u8u16_ifs.sv
// Interfaces: byte input, result output and configuration write channels.
`timescale 1ns / 1ps

interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;
  modport source (output valid, in_byte, end_of_string, input ready);
  modport sink (input valid, in_byte, end_of_string, output ready);
endinterface

interface u8u16_out_if;
  logic                         valid;
  logic                         ready;
  logic [u8u16_pkg::UNIT_W-1:0] out_unit;
  logic                         is_replacement;
  logic                         string_done;
  logic                         last_of_run;
  modport source (output valid, out_unit, is_replacement, string_done, last_of_run,
                  input ready);
  modport sink (input valid, out_unit, is_replacement, string_done, last_of_run,
                output ready);
endinterface

interface u8u16_cfg_if;
  logic valid;
  logic ready;
  logic output_format;
  modport source (output valid, output_format, input ready);
  modport sink (input valid, output_format, output ready);
endinterface

### rtl/u8u16_front.sv
// Front end: accepts bytes, runs the UTF-8 decoder state and builds queue entries.
`timescale 1ns / 1ps

module u8u16_front (
  input  logic                clk,
  input  logic                rst_n,
  u8u16_in_if.sink            in_ch,
  input  logic                fmt,
  input  logic                q_full,
  output logic                push,
  output u8u16_pkg::q_entry_t push_data
);

  logic [1:0]                   pend_r, pend_nxt;
  logic [u8u16_pkg::UNIT_W-1:0] part_r, part_nxt;
  logic [7:0]                   lo_r, lo_nxt;
  logic [7:0]                   hi_r, hi_nxt;

  logic [7:0]                   b;
  logic                         accept;

  // lead byte decode
  logic [1:0]                   lead_pend;
  logic [u8u16_pkg::UNIT_W-1:0] lead_part;
  logic [7:0]                   lead_lo;
  logic [7:0]                   lead_hi;
  logic                         lead_emit;
  logic                         lead_repl;
  logic [u8u16_pkg::UNIT_W-1:0] lead_unit;

  logic [1:0]                   k;
  logic                         use_lead;
  logic [u8u16_pkg::UNIT_W-1:0] cp;
  logic [u8u16_pkg::UNIT_W-1:0] adj;
  u8u16_pkg::q_entry_t          ent;

  assign b            = in_ch.in_byte;
  assign in_ch.ready  = ~q_full;
  assign accept       = in_ch.valid & ~q_full;

  always_comb begin
    lead_pend = 2'd0;
    lead_part = '0;
    lead_lo   = u8u16_pkg::CONT_LO;
    lead_hi   = u8u16_pkg::CONT_HI;
    lead_emit = 1'b0;
    lead_repl = 1'b0;
    lead_unit = '0;
    priority if (b < u8u16_pkg::CONT_LO) begin
      lead_emit = 1'b1;
      lead_unit = {13'd0, b};
    end else if (b >= u8u16_pkg::LEAD2_MIN && b <= u8u16_pkg::LEAD2_MAX) begin
      lead_pend = 2'd1;
      lead_part = {16'd0, b[4:0]};
    end else if (b >= u8u16_pkg::LEAD3_MIN && b <= u8u16_pkg::LEAD3_MAX) begin
      lead_pend = 2'd2;
      lead_part = {17'd0, b[3:0]};
      if (b == u8u16_pkg::LEAD_E0) lead_lo = u8u16_pkg::E0_LO;
      if (b == u8u16_pkg::LEAD_ED) lead_hi = u8u16_pkg::ED_HI;
    end else if (b >= u8u16_pkg::LEAD4_MIN && b <= u8u16_pkg::LEAD4_MAX) begin
      lead_pend = 2'd3;
      lead_part = {18'd0, b[2:0]};
      if (b == u8u16_pkg::LEAD_F0) lead_lo = u8u16_pkg::F0_LO;
      if (b == u8u16_pkg::LEAD_F4) lead_hi = u8u16_pkg::F4_HI;
    end else begin
      lead_emit = 1'b1;
      lead_repl = 1'b1;
      lead_unit = u8u16_pkg::REPL_CHAR;
    end
  end

  assign cp  = {part_r[14:0], b[5:0] & u8u16_pkg::CONT_MASK[5:0]};
  assign adj = cp - u8u16_pkg::SUPP_BASE;

  always_comb begin
    pend_nxt = pend_r;
    part_nxt = part_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    ent      = '0;
    k        = 2'd0;
    use_lead = 1'b0;

    if (pend_r != 2'd0) begin
      if (b >= lo_r && b <= hi_r) begin
        pend_nxt = pend_r - 2'd1;
        part_nxt = cp;
        lo_nxt   = u8u16_pkg::CONT_LO;
        hi_nxt   = u8u16_pkg::CONT_HI;
        if (pend_r == 2'd1) begin
          // sequence complete: go idle and emit the code point
          part_nxt = '0;
          if (fmt == u8u16_pkg::FMT_UTF16 && cp >= u8u16_pkg::SUPP_BASE) begin
            ent.unit0 = u8u16_pkg::SURR_HI_BASE + {11'd0, adj[19:10]};
            ent.unit1 = u8u16_pkg::SURR_LO_BASE + {11'd0, adj[9:0]};
            k = 2'd2;
          end else begin
            ent.unit0 = cp;
            k = 2'd1;
          end
        end
      end else begin
        // bad continuation: replace the open sequence, then retry as a lead
        ent.unit0 = u8u16_pkg::REPL_CHAR;
        ent.repl0 = 1'b1;
        k         = 2'd1;
        use_lead  = 1'b1;
      end
    end else begin
      use_lead = 1'b1;
    end

    if (use_lead) begin
      pend_nxt = lead_pend;
      part_nxt = lead_part;
      lo_nxt   = lead_lo;
      hi_nxt   = lead_hi;
      if (lead_emit) begin
        if (k == 2'd0) begin
          ent.unit0 = lead_unit;
          ent.repl0 = lead_repl;
        end else begin
          ent.unit1 = lead_unit;
          ent.repl1 = lead_repl;
        end
        k = k + 2'd1;
      end
    end

    // truncated end of string
    if (in_ch.end_of_string && pend_nxt != 2'd0) begin
      pend_nxt = 2'd0;
      part_nxt = '0;
      lo_nxt   = u8u16_pkg::CONT_LO;
      hi_nxt   = u8u16_pkg::CONT_HI;
      if (k == 2'd0) begin
        ent.unit0 = u8u16_pkg::REPL_CHAR;
        ent.repl0 = 1'b1;
      end else begin
        ent.unit1 = u8u16_pkg::REPL_CHAR;
        ent.repl1 = 1'b1;
      end
      k = k + 2'd1;
    end

    ent.two = (k == 2'd2);
    ent.eos = in_ch.end_of_string;
  end

  assign push      = accept & (k != 2'd0);
  assign push_data = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      part_r <= '0;
      lo_r   <= u8u16_pkg::CONT_LO;
      hi_r   <= u8u16_pkg::CONT_HI;
    end else if (accept) begin
      pend_r <= pend_nxt;
      part_r <= part_nxt;
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
    end
  end

endmodule

### rtl/u8u16_queue.sv
// Queue: small register FIFO of decoded entries between front and back end.
`timescale 1ns / 1ps

module u8u16_queue #(
  parameter int DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  u8u16_pkg::q_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output u8u16_pkg::q_entry_t pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  u8u16_pkg::q_entry_t mem [DEPTH];
  logic [PW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
  end

endmodule

### rtl/u8u16_back.sv
// Back end: splits queue entries into result transactions through an output register.
`timescale 1ns / 1ps

module u8u16_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  u8u16_pkg::q_entry_t q_data,
  output logic                q_pop,
  u8u16_out_if.source         out_ch
);

  logic                         valid_r;
  logic [u8u16_pkg::UNIT_W-1:0] unit_r;
  logic                         repl_r;
  logic                         done_r;
  logic                         last_r;

  // second result of a two-result entry, waiting for its turn
  logic                         sec_valid_r;
  logic [u8u16_pkg::UNIT_W-1:0] sec_unit_r;
  logic                         sec_repl_r;
  logic                         sec_eos_r;

  logic                         advance;

  assign advance = ~valid_r | out_ch.ready;
  assign q_pop   = advance & ~sec_valid_r & q_valid;

  assign out_ch.valid          = valid_r;
  assign out_ch.out_unit       = unit_r;
  assign out_ch.is_replacement = repl_r;
  assign out_ch.string_done    = done_r;
  assign out_ch.last_of_run    = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      sec_valid_r <= 1'b0;
    end else if (advance) begin
      if (sec_valid_r) begin
        valid_r     <= 1'b1;
        sec_valid_r <= 1'b0;
      end else begin
        valid_r     <= q_valid;
        sec_valid_r <= q_valid & q_data.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (sec_valid_r) begin
        unit_r <= sec_unit_r;
        repl_r <= sec_repl_r;
        done_r <= sec_eos_r;
        last_r <= 1'b1;
      end else begin
        unit_r     <= q_data.unit0;
        repl_r     <= q_data.repl0;
        done_r     <= q_data.eos & ~q_data.two;
        last_r     <= ~q_data.two;
        sec_unit_r <= q_data.unit1;
        sec_repl_r <= q_data.repl1;
        sec_eos_r  <= q_data.eos;
      end
    end
  end

endmodule

### rtl/utf8_to_utf16_transcoder.sv
// Top level: UTF-8 byte stream to UTF-32 code points or UTF-16 code units.
// A byte's first result passes through the queue and then the output register.
// Throughput: one byte per cycle while the queue is not full; a byte with two results gives two output transactions.
// Bytes that finish nothing produce no transaction.
// rst_n is synchronous, active low: decoder idle, queue empty, output format UTF-32.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder #(
  parameter int QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  u8u16_in_if.sink     in_ch,
  u8u16_out_if.source  out_ch,
  u8u16_cfg_if.sink    cfg_ch
);

  // Output format register. It is to be only written while the block is idle, a rule for the user
  // that the block itself does not enforce, so that the front end may apply it at decode time.
  logic                fmt_r;

  logic                q_full;
  logic                q_push;
  u8u16_pkg::q_entry_t q_push_data;
  logic                q_pop;
  logic                q_valid;
  u8u16_pkg::q_entry_t q_pop_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= u8u16_pkg::FMT_UTF32;
    end else if (cfg_ch.valid) begin
      fmt_r <= cfg_ch.output_format;
    end
  end

  // Front end: validate each byte against the allowed range, gather code
  // point bits, and pack the byte's one or two results into a queue entry.
  u8u16_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .fmt       (fmt_r),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  // Decoupling queue: holds entries while a two-result byte is sent or the output
  // stalls; the input side is stopped only when the queue is full.
  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_pop_data)
  );

  // Back end: present each result as one output transaction, flag the last
  // of each byte and the end of the string.
  u8u16_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_pop_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

### rtl/u8u16_checker.sv
// Checker: port-level assertions for the transcoder, bound to the top level.
`timescale 1ns / 1ps

module u8u16_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [u8u16_pkg::UNIT_W-1:0] out_unit,
  input logic                         is_replacement,
  input logic                         string_done,
  input logic                         last_of_run
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_unit) &&
      $stable(is_replacement) && $stable(string_done) && $stable(last_of_run))
    else $error("stalled result changed");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && string_done |-> last_of_run)
    else $error("string_done without last_of_run");

  a_repl_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_replacement |-> out_unit == u8u16_pkg::REPL_CHAR)
    else $error("replacement flag on a unit other than U+FFFD");

  // the second result of a byte follows right after the first is taken
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_of_run |=> out_valid && last_of_run)
    else $error("second result of a byte did not follow");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_unit       (out_ch.out_unit),
  .is_replacement (out_ch.is_replacement),
  .string_done    (out_ch.string_done),
  .last_of_run    (out_ch.last_of_run)
);
